FILE: src/assert_macros.svh
// Assertion macros shared by the fixed-point ALU RTL.
// Defining NO_ASSERTIONS compiles every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define FXALU_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FXALU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FXALU_ASSERT(lbl, clk, rst_n, prop, msg)
`define FXALU_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

FILE: src/fxalu_pkg.sv
// Opcodes, status codes and saturation bounds of the fixed-point ALU.
// Has no dependencies.
package fxalu_pkg;

    typedef enum logic [3:0] {
        CMD_ADD     = 4'd0,
        CMD_SUB     = 4'd1,
        CMD_MUL     = 4'd2,
        CMD_DIV     = 4'd3,
        CMD_GT      = 4'd4,
        CMD_LT      = 4'd5,
        CMD_GE      = 4'd6,
        CMD_LE      = 4'd7,
        CMD_EQ      = 4'd8,
        CMD_NE      = 4'd9,
        CMD_INC     = 4'd10,
        CMD_DEC     = 4'd11,
        CMD_MAX     = 4'd12,
        CMD_MIN     = 4'd13,
        CMD_TOINT   = 4'd14,
        CMD_FROMINT = 4'd15
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_DIV_ZERO = 2'd2
    } t_status;

    localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] S32_MIN = 32'h8000_0000;

endpackage

FILE: src/fixed_point_q24_8_alu_core.sv
// Top level of the signed fixed-point ALU: a fully pipelined datapath.
// Depends on fxalu_pkg and assert_macros.svh.
//
// Usage:
// The input channel (i_valid, o_stall) carries an opcode and two raw operands;
// the output channel (o_valid, i_stall) returns a raw result, a compare flag
// and a status for every beat, in order.
// Every operation passes the input register, the result stage, the divider
// stages and the output register before o_valid. The length is set by the
// divider, which resolves one quotient bit per stage over 32 + FRAC_BITS
// stages; all other operations travel the same pipeline to keep order.
// One beat is accepted every cycle while the output is not stalled.
// When the receiver stalls a valid result, the whole pipeline holds and
// o_stall rises; nothing is dropped or repeated.
// Reset clears every stage valid bit; operand and result registers are
// not reset. The block keeps no state between operations.
`include "assert_macros.svh"

module fixed_point_q24_8_alu_core #(
    parameter int FRAC_BITS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [3:0]         i_cmd,
    input  logic signed [31:0] i_operand_a,
    input  logic signed [31:0] i_operand_b,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_result_raw,
    output logic               o_compare_flag,
    output logic [1:0]         o_status
);

    localparam int NW = 32 + FRAC_BITS;

    typedef struct packed {
        logic               valid;
        fxalu_pkg::t_cmd    cmd;
        logic [31:0]        res;
        logic               flag;
        fxalu_pkg::t_status status;
        logic [63:0]        prod;
        logic               neg;
        logic               a_neg;
        logic               dz;
        logic [NW-1:0]      num;
        logic [31:0]        den;
        logic [31:0]        rem;
        logic [NW-1:0]      quo;
    } t_stage;

    logic                  w_adv;
    logic                  r_a_valid;
    fxalu_pkg::t_cmd       r_a_cmd;
    logic signed [31:0]    r_a_a;
    logic signed [31:0]    r_a_b;
    t_stage                r_b;
    t_stage                n_b;
    t_stage                r_d [NW];
    t_stage                n_d [NW];
    logic                  r_e_valid;
    logic [31:0]           r_e_res;
    logic                  r_e_flag;
    fxalu_pkg::t_status    r_e_status;
    logic [31:0]           n_e_res;
    fxalu_pkg::t_status    n_e_status;

    logic [32:0]           w_sum;
    logic [32:0]           w_dif;
    logic [32:0]           w_inc;
    logic [32:0]           w_dec;
    logic signed [63:0]    w_shl;
    logic signed [63:0]    w_prod;
    logic [NW:0]           w_qmag;

    assign w_adv   = !(r_e_valid && i_stall);
    assign o_stall = !w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_adv) begin
            r_a_valid <= i_valid;
            r_a_cmd   <= fxalu_pkg::t_cmd'(i_cmd);
            r_a_a     <= i_operand_a;
            r_a_b     <= i_operand_b;
        end
    end

    assign w_sum  = {r_a_a[31], r_a_a} + {r_a_b[31], r_a_b};
    assign w_dif  = {r_a_a[31], r_a_a} - {r_a_b[31], r_a_b};
    assign w_inc  = {r_a_a[31], r_a_a} + 33'd1;
    assign w_dec  = {r_a_a[31], r_a_a} - 33'd1;
    assign w_shl  = 64'(r_a_a) <<< FRAC_BITS;
    assign w_prod = 64'(r_a_a) * 64'(r_a_b);

    always_comb begin
        n_b        = '0;
        n_b.valid  = r_a_valid;
        n_b.cmd    = r_a_cmd;
        n_b.status = fxalu_pkg::ST_OK;
        n_b.prod   = w_prod;
        n_b.a_neg  = r_a_a[31];
        n_b.neg    = r_a_a[31] ^ r_a_b[31];
        n_b.dz     = (r_a_b == 32'sd0);
        n_b.num    = {(r_a_a[31] ? 32'(-r_a_a) : 32'(r_a_a)), {FRAC_BITS{1'b0}}};
        n_b.den    = r_a_b[31] ? 32'(-r_a_b) : 32'(r_a_b);
        unique case (r_a_cmd)
            fxalu_pkg::CMD_ADD, fxalu_pkg::CMD_SUB,
            fxalu_pkg::CMD_INC, fxalu_pkg::CMD_DEC: begin
                logic [32:0] s;
                unique case (r_a_cmd)
                    fxalu_pkg::CMD_ADD: s = w_sum;
                    fxalu_pkg::CMD_SUB: s = w_dif;
                    fxalu_pkg::CMD_INC: s = w_inc;
                    default:            s = w_dec;
                endcase
                if (s[32] != s[31]) begin
                    n_b.res    = s[32] ? fxalu_pkg::S32_MIN : fxalu_pkg::S32_MAX;
                    n_b.status = fxalu_pkg::ST_OVERFLOW;
                end else begin
                    n_b.res = s[31:0];
                end
            end
            fxalu_pkg::CMD_GT: n_b.flag = (r_a_a > r_a_b);
            fxalu_pkg::CMD_LT: n_b.flag = (r_a_a < r_a_b);
            fxalu_pkg::CMD_GE: n_b.flag = (r_a_a >= r_a_b);
            fxalu_pkg::CMD_LE: n_b.flag = (r_a_a <= r_a_b);
            fxalu_pkg::CMD_EQ: n_b.flag = (r_a_a == r_a_b);
            fxalu_pkg::CMD_NE: n_b.flag = (r_a_a != r_a_b);
            fxalu_pkg::CMD_MAX: n_b.res = (r_a_a < r_a_b) ? r_a_b : r_a_a;
            fxalu_pkg::CMD_MIN: n_b.res = (r_a_a > r_a_b) ? r_a_b : r_a_a;
            fxalu_pkg::CMD_TOINT: n_b.res = 32'(r_a_a >>> FRAC_BITS);
            fxalu_pkg::CMD_FROMINT: begin
                if (w_shl[63:31] != {33{w_shl[63]}}) begin
                    n_b.res    = w_shl[63] ? fxalu_pkg::S32_MIN : fxalu_pkg::S32_MAX;
                    n_b.status = fxalu_pkg::ST_OVERFLOW;
                end else begin
                    n_b.res = w_shl[31:0];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b.valid <= 1'b0;
        end else if (w_adv) begin
            r_b <= n_b;
        end
    end

    for (genvar k = 0; k < NW; k++) begin : g_div
        localparam int BIT = NW - 1 - k;
        t_stage p;
        if (k == 0) begin : g_first
            assign p = r_b;
        end else begin : g_next
            assign p = r_d[k-1];
        end

        always_comb begin
            logic [32:0] sh;
            logic [63:0] m;
            sh = {p.rem, p.num[BIT]};
            m  = '0;
            n_d[k] = p;
            if (sh >= {1'b0, p.den}) begin
                n_d[k].rem    = 32'(sh - {1'b0, p.den});
                n_d[k].quo[BIT] = 1'b1;
            end else begin
                n_d[k].rem = sh[31:0];
            end
            if (k == 0 && p.cmd == fxalu_pkg::CMD_MUL) begin
                m = p.prod[63] ? 64'(-p.prod) : p.prod;
                n_d[k].prod = (m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
                n_d[k].neg  = p.prod[63];
            end
            if (k == 1 && p.cmd == fxalu_pkg::CMD_MUL) begin
                if (p.neg) begin
                    if (p.prod > 64'h8000_0000) begin
                        n_d[k].res    = fxalu_pkg::S32_MIN;
                        n_d[k].status = fxalu_pkg::ST_OVERFLOW;
                    end else begin
                        n_d[k].res = 32'(-p.prod[31:0]);
                    end
                end else if (p.prod > 64'h7FFF_FFFF) begin
                    n_d[k].res    = fxalu_pkg::S32_MAX;
                    n_d[k].status = fxalu_pkg::ST_OVERFLOW;
                end else begin
                    n_d[k].res = p.prod[31:0];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d[k].valid <= 1'b0;
            end else if (w_adv) begin
                r_d[k] <= n_d[k];
            end
        end
    end

    assign w_qmag = {1'b0, r_d[NW-1].quo}
        + (({r_d[NW-1].rem, 1'b0} >= {1'b0, r_d[NW-1].den}) ? (NW+1)'(1) : (NW+1)'(0));

    always_comb begin
        n_e_res    = r_d[NW-1].res;
        n_e_status = r_d[NW-1].status;
        if (r_d[NW-1].cmd == fxalu_pkg::CMD_DIV) begin
            if (r_d[NW-1].dz) begin
                n_e_status = fxalu_pkg::ST_DIV_ZERO;
                n_e_res    = r_d[NW-1].a_neg ? fxalu_pkg::S32_MIN : fxalu_pkg::S32_MAX;
            end else if (r_d[NW-1].neg) begin
                if (w_qmag > (NW+1)'(64'h8000_0000)) begin
                    n_e_status = fxalu_pkg::ST_OVERFLOW;
                    n_e_res    = fxalu_pkg::S32_MIN;
                end else begin
                    n_e_res = 32'(-w_qmag[31:0]);
                end
            end else if (w_qmag > (NW+1)'(64'h7FFF_FFFF)) begin
                n_e_status = fxalu_pkg::ST_OVERFLOW;
                n_e_res    = fxalu_pkg::S32_MAX;
            end else begin
                n_e_res = w_qmag[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else if (w_adv) begin
            r_e_valid  <= r_d[NW-1].valid;
            r_e_res    <= n_e_res;
            r_e_flag   <= r_d[NW-1].flag;
            r_e_status <= n_e_status;
        end
    end

    assign o_valid        = r_e_valid;
    assign o_result_raw   = r_e_res;
    assign o_compare_flag = r_e_flag;
    assign o_status       = r_e_status;

    `FXALU_ASSERT_ALWAYS(a_reset_empty, i_clk, !$past(i_rst_n) |-> !o_valid, "valid after reset")
    `FXALU_ASSERT(a_cmp_clean, i_clk, i_rst_n, (o_valid && o_compare_flag) |-> (o_result_raw == 32'sd0 && o_status == fxalu_pkg::ST_OK), "compare result not clean")
    `FXALU_ASSERT(a_dz_sat, i_clk, i_rst_n, (o_valid && o_status == fxalu_pkg::ST_DIV_ZERO) |-> (o_result_raw == fxalu_pkg::S32_MAX || o_result_raw == fxalu_pkg::S32_MIN), "divide by zero not saturated")
    `FXALU_ASSERT(a_last_moves, i_clk, i_rst_n, (r_d[NW-1].valid && w_adv) |=> o_valid, "last stage beat lost")

endmodule

FILE: dv/tb_fixed_point_q24_8_alu_core.sv
// Testbench for the Q24.8 fixed-point ALU core: a directed table, then random
// beats under changing idle patterns, checked against the table or a predictor.
// Depends on fxalu_pkg and the RTL top level fixed_point_q24_8_alu_core.
module tb_fixed_point_q24_8_alu_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = 8;
    localparam int LATENCY = FRAC + 34;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int N_RANDOM = 1200;

    typedef struct {
        fxalu_pkg::t_cmd cmd;
        logic [31:0]     a;
        logic [31:0]     b;
    } t_alu_op;

    typedef struct packed {
        logic [31:0]        res;
        logic               flag;
        fxalu_pkg::t_status st;
    } t_alu_res;

    typedef struct {
        t_alu_op  op;
        bit       known;
        t_alu_res res;
    } t_table_row;

    logic i_clk, i_rst_n, i_valid, o_stall, i_stall, o_valid, o_compare_flag;
    logic [3:0] i_cmd;
    logic signed [31:0] i_operand_a, i_operand_b, o_result_raw;
    logic [1:0] o_status;

    t_alu_res   expected_results[$];
    t_table_row directed[$];
    int         errors;
    int         idle_cycles;
    int         send_idle_pct, recv_idle_pct;
    bit         sending_done;

    fixed_point_q24_8_alu_core #(.FRAC_BITS(FRAC)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_cmd(i_cmd), .i_operand_a(i_operand_a), .i_operand_b(i_operand_b),
        .o_valid(o_valid), .i_stall(i_stall), .o_result_raw(o_result_raw),
        .o_compare_flag(o_compare_flag), .o_status(o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_alu_res saturate(longint v);
        t_alu_res r;
        r.flag = 1'b0;
        r.st = fxalu_pkg::ST_OK;
        if (v > 64'sd2147483647) begin
            r.res = fxalu_pkg::S32_MAX;
            r.st = fxalu_pkg::ST_OVERFLOW;
        end else if (v < -64'sd2147483648) begin
            r.res = fxalu_pkg::S32_MIN;
            r.st = fxalu_pkg::ST_OVERFLOW;
        end else begin
            r.res = v[31:0];
        end
        return r;
    endfunction

    function automatic t_alu_res alu_predict(t_alu_op op);
        longint a, b, p, q, rem;
        longint unsigned m, num, den;
        t_alu_res r;
        a = longint'($signed(op.a));
        b = longint'($signed(op.b));
        r.res = '0;
        r.flag = 1'b0;
        r.st = fxalu_pkg::ST_OK;
        case (op.cmd)
            fxalu_pkg::CMD_ADD: r = saturate(a + b);
            fxalu_pkg::CMD_SUB: r = saturate(a - b);
            fxalu_pkg::CMD_MUL: begin
                p = a * b;
                m = (p < 0) ? -p : p;
                m = (m + (64'd1 << (FRAC - 1))) >> FRAC;
                r = saturate((p < 0) ? -longint'(m) : longint'(m));
            end
            fxalu_pkg::CMD_DIV: begin
                if (b == 0) begin
                    r.res = (a < 0) ? fxalu_pkg::S32_MIN : fxalu_pkg::S32_MAX;
                    r.st = fxalu_pkg::ST_DIV_ZERO;
                end else begin
                    num = ((a < 0) ? -a : a) << FRAC;
                    den = (b < 0) ? -b : b;
                    q = num / den;
                    rem = num % den;
                    if (2 * rem >= den) q++;
                    r = saturate(((a < 0) != (b < 0)) ? -q : q);
                end
            end
            fxalu_pkg::CMD_GT: r.flag = a > b;
            fxalu_pkg::CMD_LT: r.flag = a < b;
            fxalu_pkg::CMD_GE: r.flag = a >= b;
            fxalu_pkg::CMD_LE: r.flag = a <= b;
            fxalu_pkg::CMD_EQ: r.flag = a == b;
            fxalu_pkg::CMD_NE: r.flag = a != b;
            fxalu_pkg::CMD_INC: r = saturate(a + 1);
            fxalu_pkg::CMD_DEC: r = saturate(a - 1);
            fxalu_pkg::CMD_MAX: r.res = (a < b) ? op.b : op.a;
            fxalu_pkg::CMD_MIN: r.res = (a > b) ? op.b : op.a;
            fxalu_pkg::CMD_TOINT: r.res = $signed(op.a) >>> FRAC;
            default: r = saturate(a * (64'sd1 <<< FRAC));
        endcase
        return r;
    endfunction

    task automatic send_beat(t_alu_op op, bit known, t_alu_res given);
        t_alu_res model_res;
        while (!sending_done && ($urandom_range(99) < send_idle_pct)) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd <= op.cmd;
        i_operand_a <= op.a;
        i_operand_b <= op.b;
        model_res = alu_predict(op);
        if (known && model_res != given)
            $display("%0t table row disagrees with predictor: cmd %0d", $time, op.cmd);
        expected_results.push_back(known ? given : model_res);
        do @(posedge i_clk); while (o_stall);
    endtask

    function automatic logic [31:0] random_operand();
        case ($urandom_range(5))
            0: return {$urandom_range(1) ? 32'hFFFF_FF00 : 32'h0} | $urandom_range(255);
            1: return $urandom_range(1) ? fxalu_pkg::S32_MAX - $urandom_range(3)
                                        : fxalu_pkg::S32_MIN + $urandom_range(3);
            2: return $signed($urandom_range(2047)) - 1024;
            3: return {{16{$urandom_range(1) == 1}}, 16'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    function automatic t_table_row row(fxalu_pkg::t_cmd c, logic [31:0] a, logic [31:0] b,
                                       bit known = 0, logic [31:0] res = '0,
                                       logic flag = 0,
                                       fxalu_pkg::t_status st = fxalu_pkg::ST_OK);
        t_table_row t;
        t.op.cmd = c;
        t.op.a = a;
        t.op.b = b;
        t.known = known;
        t.res.res = res;
        t.res.flag = flag;
        t.res.st = st;
        return t;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
            if (o_valid && !i_stall) begin
                if (expected_results.size() == 0) begin
                    $display("%0t unexpected beat: result %h flag %b status %0d", $time,
                             o_result_raw, o_compare_flag, o_status);
                    errors++;
                end else begin
                    t_alu_res e;
                    e = expected_results.pop_front();
                    if (o_result_raw !== e.res) begin
                        $display("%0t result_raw expected %h actual %h", $time, e.res,
                                 o_result_raw);
                        errors++;
                    end
                    if (o_compare_flag !== e.flag) begin
                        $display("%0t compare_flag expected %b actual %b", $time, e.flag,
                                 o_compare_flag);
                        errors++;
                    end
                    if (o_status !== e.st) begin
                        $display("%0t status expected %0d actual %0d", $time, e.st,
                                 o_status);
                        errors++;
                    end
                end
            end
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        t_alu_op op;
        t_alu_res none;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_cmd = fxalu_pkg::CMD_ADD;
        i_operand_a = '0;
        i_operand_b = '0;
        errors = 0;
        idle_cycles = 0;
        sending_done = 0;
        send_idle_pct = 19;
        recv_idle_pct = 75;
        none = '{res: '0, flag: 0, st: fxalu_pkg::ST_OK};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        directed.push_back(row(fxalu_pkg::CMD_ADD, fxalu_pkg::S32_MAX, 32'd1,
                               1, fxalu_pkg::S32_MAX, 0, fxalu_pkg::ST_OVERFLOW));
        directed.push_back(row(fxalu_pkg::CMD_ADD, fxalu_pkg::S32_MIN, 32'hFFFF_FFFF,
                               1, fxalu_pkg::S32_MIN, 0, fxalu_pkg::ST_OVERFLOW));
        directed.push_back(row(fxalu_pkg::CMD_SUB, fxalu_pkg::S32_MIN, 32'd1,
                               1, fxalu_pkg::S32_MIN, 0, fxalu_pkg::ST_OVERFLOW));
        directed.push_back(row(fxalu_pkg::CMD_SUB, 32'd0, fxalu_pkg::S32_MIN,
                               1, fxalu_pkg::S32_MAX, 0, fxalu_pkg::ST_OVERFLOW));
        directed.push_back(row(fxalu_pkg::CMD_MUL, fxalu_pkg::S32_MAX, fxalu_pkg::S32_MAX,
                               1, fxalu_pkg::S32_MAX, 0, fxalu_pkg::ST_OVERFLOW));
        directed.push_back(row(fxalu_pkg::CMD_MUL, 32'd1, 32'd128));
        directed.push_back(row(fxalu_pkg::CMD_MUL, 32'hFFFF_FFFF, 32'd128));
        directed.push_back(row(fxalu_pkg::CMD_MUL, fxalu_pkg::S32_MIN, fxalu_pkg::S32_MIN,
                               1, fxalu_pkg::S32_MAX, 0, fxalu_pkg::ST_OVERFLOW));
        directed.push_back(row(fxalu_pkg::CMD_DIV, 32'd5, 32'd0,
                               1, fxalu_pkg::S32_MAX, 0, fxalu_pkg::ST_DIV_ZERO));
        directed.push_back(row(fxalu_pkg::CMD_DIV, 32'd0, 32'd0,
                               1, fxalu_pkg::S32_MAX, 0, fxalu_pkg::ST_DIV_ZERO));
        directed.push_back(row(fxalu_pkg::CMD_DIV, 32'hFFFF_FFFB, 32'd0,
                               1, fxalu_pkg::S32_MIN, 0, fxalu_pkg::ST_DIV_ZERO));
        directed.push_back(row(fxalu_pkg::CMD_DIV, fxalu_pkg::S32_MIN, 32'd1,
                               1, fxalu_pkg::S32_MIN, 0, fxalu_pkg::ST_OVERFLOW));
        directed.push_back(row(fxalu_pkg::CMD_DIV, 32'd1, 32'd512));
        directed.push_back(row(fxalu_pkg::CMD_GT, fxalu_pkg::S32_MAX, fxalu_pkg::S32_MIN,
                               1, '0, 1, fxalu_pkg::ST_OK));
        directed.push_back(row(fxalu_pkg::CMD_LT, fxalu_pkg::S32_MAX, fxalu_pkg::S32_MIN,
                               1, '0, 0, fxalu_pkg::ST_OK));
        directed.push_back(row(fxalu_pkg::CMD_GE, 32'd7, 32'd7,
                               1, '0, 1, fxalu_pkg::ST_OK));
        directed.push_back(row(fxalu_pkg::CMD_LE, 32'd8, 32'd7,
                               1, '0, 0, fxalu_pkg::ST_OK));
        directed.push_back(row(fxalu_pkg::CMD_EQ, fxalu_pkg::S32_MIN, fxalu_pkg::S32_MIN,
                               1, '0, 1, fxalu_pkg::ST_OK));
        directed.push_back(row(fxalu_pkg::CMD_NE, fxalu_pkg::S32_MIN, fxalu_pkg::S32_MIN,
                               1, '0, 0, fxalu_pkg::ST_OK));
        directed.push_back(row(fxalu_pkg::CMD_INC, fxalu_pkg::S32_MAX, 32'd0,
                               1, fxalu_pkg::S32_MAX, 0, fxalu_pkg::ST_OVERFLOW));
        directed.push_back(row(fxalu_pkg::CMD_DEC, fxalu_pkg::S32_MIN, 32'd0,
                               1, fxalu_pkg::S32_MIN, 0, fxalu_pkg::ST_OVERFLOW));
        directed.push_back(row(fxalu_pkg::CMD_MAX, fxalu_pkg::S32_MIN, fxalu_pkg::S32_MAX,
                               1, fxalu_pkg::S32_MAX, 0, fxalu_pkg::ST_OK));
        directed.push_back(row(fxalu_pkg::CMD_MIN, fxalu_pkg::S32_MIN, fxalu_pkg::S32_MAX,
                               1, fxalu_pkg::S32_MIN, 0, fxalu_pkg::ST_OK));
        directed.push_back(row(fxalu_pkg::CMD_TOINT, 32'hFFFF_FFFF, 32'd0,
                               1, 32'hFFFF_FFFF, 0, fxalu_pkg::ST_OK));
        directed.push_back(row(fxalu_pkg::CMD_FROMINT, 32'h0080_0000, 32'd0,
                               1, fxalu_pkg::S32_MAX, 0, fxalu_pkg::ST_OVERFLOW));

        foreach (directed[i]) send_beat(directed[i].op, directed[i].known, directed[i].res);
        i_valid <= 1'b0;

        // The sender holds off until the pipeline has drained.
        wait (expected_results.size() == 0);
        @(posedge i_clk);

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM / 3) begin
                send_idle_pct = 75;
                recv_idle_pct = 19;
            end else if (i == 2 * N_RANDOM / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            op.cmd = fxalu_pkg::t_cmd'($urandom_range(15));
            op.a = random_operand();
            op.b = ($urandom_range(9) == 0) ? op.a : random_operand();
            if ($urandom_range(15) == 0) op.b = '0;
            send_beat(op, 0, none);
        end
        i_valid <= 1'b0;
        sending_done = 1;
        recv_idle_pct = 0;

        fork
            wait (expected_results.size() == 0);
            begin
                repeat (WATCHDOG_LIMIT) @(posedge i_clk);
            end
        join_any
        disable fork;
        repeat (LATENCY + 10) @(posedge i_clk);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
